// ===== rtl/core/bts_pkg.sv =====
package bts_pkg;

  // Pixel store geometry: one RGBA8 word per entry, row-major.
  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int PIX_W       = 32;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 4;

  // Coordinate and stream widths.
  localparam int COORD_W   = 16;
  localparam int IN_DATA_W = 80;
  localparam int IN_USER_W = 1;

  // Four neighbors per sample, one store read each.
  localparam int NUM_TAPS = 4;
  localparam int PHASE_W  = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Result queue depth; also the number of samples allowed in flight.
  localparam int OUT_FIFO_DEPTH = 2;

  // Parameter defaults.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 8;

  // Item kinds.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // One request to the single store port.
  typedef struct packed {
    logic                en;
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [PIX_W-1:0]    wdata;
  } mem_req_t;

  // Sideband that travels with a store read into the accumulator.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic err;
  } tag_t;

endpackage

// ===== rtl/core/bts_store.sv =====
module bts_store (
  input  logic                      clk,
  input  bts_pkg::mem_req_t         mem_req,
  output logic [bts_pkg::PIX_W-1:0] rd_data
);
  import bts_pkg::*;

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  // Single port: a write or a registered read each cycle.
  always_ff @(posedge clk) begin
    if (mem_req.en) begin
      if (mem_req.we) begin
        mem[mem_req.addr] <= mem_req.wdata;
      end else begin
        rd_data <= mem[mem_req.addr];
      end
    end
  end

endmodule

// ===== rtl/core/bts_issue.sv =====
module bts_issue #(
  parameter int MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bts_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [bts_pkg::STORE_AW-1:0]   in_index,
  input  logic [bts_pkg::PIX_W-1:0]      in_pixel,
  input  logic [bts_pkg::COORD_W-1:0]    in_sx,
  input  logic [bts_pkg::COORD_W-1:0]    in_sy,
  input  logic                           out_pop,
  output bts_pkg::mem_req_t              mem_req,
  output bts_pkg::tag_t                  tag,
  output logic [2*FRAC_BITS:0]           weight
);
  import bts_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int IW    = COORD_W - FRAC_BITS;
  localparam int CW    = ((IW > 0) ? IW : 1) + 1;
  localparam int PW    = CW + WW + 1;
  localparam int FW    = FRAC_BITS + 1;
  localparam int WB    = 2 * FRAC_BITS + 1;
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  // Image size, clamped into 1..MAX when written.
  logic [WW-1:0] w_eff_r;
  logic [HW-1:0] h_eff_r;
  logic [WW-1:0] w_cfg;
  logic [HW-1:0] h_cfg;

  always_comb begin
    if (cfg_data == '0) begin
      w_cfg = WW'(1);
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      w_cfg = WW'(MAX_WIDTH);
    end else begin
      w_cfg = WW'(cfg_data);
    end
    if (cfg_data == '0) begin
      h_cfg = HW'(1);
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      h_cfg = HW'(MAX_HEIGHT);
    end else begin
      h_cfg = HW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WW'(1);
      h_eff_r <= HW'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  w_eff_r <= w_cfg;
        REG_IMAGE_HEIGHT: h_eff_r <= h_cfg;
        default: begin
        end
      endcase
    end
  end

  // Decode the incoming coordinates into neighbor positions and fractions.
  logic [31:0]          sx_ext, sy_ext, x_lim, y_lim;
  logic                 err_in;
  logic [CW-1:0]        x0_in, x1_in, y0_in, y1_in;
  logic [FRAC_BITS-1:0] fx_in, fy_in;

  always_comb begin
    sx_ext = 32'(in_sx);
    sy_ext = 32'(in_sy);
    x_lim  = (32'(w_eff_r) - 32'd1) << FRAC_BITS;
    y_lim  = (32'(h_eff_r) - 32'd1) << FRAC_BITS;
    err_in = (sx_ext > x_lim) || (sy_ext > y_lim);
    x0_in  = CW'(sx_ext >> FRAC_BITS);
    y0_in  = CW'(sy_ext >> FRAC_BITS);
    x1_in  = ((32'(x0_in) + 32'd1) < 32'(w_eff_r)) ? x0_in + CW'(1) : x0_in;
    y1_in  = ((32'(y0_in) + 32'd1) < 32'(h_eff_r)) ? y0_in + CW'(1) : y0_in;
    fx_in  = in_sx[FRAC_BITS-1:0];
    fy_in  = in_sy[FRAC_BITS-1:0];
  end

  // Held item.
  logic                 cmd_r, err_r;
  logic [STORE_AW-1:0]  index_r;
  logic [PIX_W-1:0]     pixel_r;
  logic [CW-1:0]        x0_r, x1_r, y0_r, y1_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;

  // Control state.
  logic               busy_r, busy_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic needs_credit, fire, last_step, accept;

  // A sample claims a result slot before its first read; later reads just follow.
  always_comb begin
    needs_credit = (cmd_r == CMD_SAMPLE) && (phase_r == '0);
    fire         = busy_r && (!needs_credit || (cnt_r < CNT_W'(OUT_FIFO_DEPTH)));
    last_step    = (cmd_r == CMD_WRITE) || err_r || (phase_r == PHASE_W'(NUM_TAPS - 1));
    in_ready     = !busy_r || (fire && last_step);
    accept       = in_valid && in_ready;
  end

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    if (accept) begin
      busy_nxt  = 1'b1;
      phase_nxt = '0;
    end else if (fire && last_step) begin
      busy_nxt  = 1'b0;
      phase_nxt = '0;
    end else if (fire) begin
      phase_nxt = phase_r + PHASE_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(fire && needs_credit) - CNT_W'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      err_r   <= (in_cmd == CMD_SAMPLE) && err_in;
      index_r <= in_index;
      pixel_r <= in_pixel;
      x0_r    <= x0_in;
      x1_r    <= x1_in;
      y0_r    <= y0_in;
      y1_r    <= y1_in;
      fx_r    <= fx_in;
      fy_r    <= fy_in;
    end
  end

  // Per-read address and weight: phase bit 0 picks the right column, bit 1 the lower row.
  logic [CW-1:0]   x_sel, y_sel;
  logic [PW-1:0]   lin;
  logic [FW-1:0]   one_v, a_fac, b_fac;
  logic [2*FW-1:0] w_prod;

  always_comb begin
    x_sel  = phase_r[0] ? x1_r : x0_r;
    y_sel  = phase_r[1] ? y1_r : y0_r;
    lin    = PW'(y_sel) * PW'(w_eff_r) + PW'(x_sel);
    one_v  = FW'(1) << FRAC_BITS;
    a_fac  = phase_r[0] ? FW'(fx_r) : one_v - FW'(fx_r);
    b_fac  = phase_r[1] ? FW'(fy_r) : one_v - FW'(fy_r);
    w_prod = (2 * FW)'(a_fac) * (2 * FW)'(b_fac);
    weight = w_prod[WB-1:0];
  end

  always_comb begin
    mem_req.en    = fire && !((cmd_r == CMD_SAMPLE) && err_r);
    mem_req.we    = (cmd_r == CMD_WRITE);
    mem_req.addr  = (cmd_r == CMD_WRITE) ? index_r : STORE_AW'(lin);
    mem_req.wdata = pixel_r;
    tag.vld       = fire && (cmd_r == CMD_SAMPLE);
    tag.first     = (phase_r == '0);
    tag.last      = last_step;
    tag.err       = err_r;
  end

endmodule

// ===== rtl/core/bts_accum.sv =====
module bts_accum #(
  parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bts_pkg::tag_t             tag,
  input  logic [2*FRAC_BITS:0]      weight,
  input  logic [bts_pkg::PIX_W-1:0] rd_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bts_pkg::PIX_W-1:0] out_color,
  output logic                      out_err
);
  import bts_pkg::*;

  localparam int WB    = 2 * FRAC_BITS + 1;
  localparam int AW    = CHAN_W + WB;
  localparam int PTR_W = (OUT_FIFO_DEPTH > 1) ? $clog2(OUT_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  // Sideband aligned with the store's registered read data.
  tag_t          tag_r;
  logic [WB-1:0] weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag;
    end
    weight_r <= weight;
  end

  // One multiply-add lane per channel.
  logic [AW-1:0]    acc_r   [NUM_CHAN];
  logic [AW-1:0]    sum     [NUM_CHAN];
  logic [PIX_W-1:0] res_color;
  logic             push;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum[c] = (tag_r.first ? '0 : acc_r[c]) +
               AW'(AW'(rd_data[c*CHAN_W +: CHAN_W]) * AW'(weight_r));
      res_color[c*CHAN_W +: CHAN_W] = tag_r.err ? '0 : sum[c][2*FRAC_BITS +: CHAN_W];
    end
    push = tag_r.vld && tag_r.last;
  end

  always_ff @(posedge clk) begin
    if (tag_r.vld) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        acc_r[c] <= sum[c];
      end
    end
  end

  // Result queue; slots are reserved upstream, so a push always finds room.
  logic [PIX_W-1:0] q_color_r [OUT_FIFO_DEPTH];
  logic             q_err_r   [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic             pop;

  always_comb begin
    out_valid  = (q_cnt_r != '0);
    pop        = out_valid && out_ready;
    out_color  = q_color_r[rd_ptr_r];
    out_err    = q_err_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    q_cnt_nxt = q_cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_color_r[wr_ptr_r] <= res_color;
      q_err_r[wr_ptr_r]   <= tag_r.err;
    end
  end

endmodule

// ===== rtl/core/bilinear_texture_sampler_unit.sv =====
// Bilinear RGBA8 texture sampler. A write item (tuser 0) stores one pixel at a row-major
// index; a sample item (tuser 1) reads its four neighbors from the one single-ported
// pixel store, one read per cycle once a result slot is free for it, and writes can follow
// samples back to back. A sample outside the image does no store read and returns zero
// color with the error flag. Up to two results may wait at the output; a further sample
// is then held before its first read until one is taken, and no new item is accepted
// meanwhile. Image width and height are written on the configuration port while the
// block is idle; the user must keep to this, the block itself does not enforce it. The
// store has no reset: sample only pixels that were written.
module bilinear_texture_sampler_unit #(
  parameter int MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bts_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pixel_index, in_red, in_green, in_blue, in_alpha, sample_x, sample_y
  input  logic [bts_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [bts_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [bts_pkg::PIX_W-1:0]      out_tdata,
  // range_error
  output logic                           out_tuser
);
  import bts_pkg::*;

  mem_req_t            mem_req;
  tag_t                tag;
  logic [2*FRAC_BITS:0] weight;
  logic [PIX_W-1:0]    rd_data;
  logic                out_pop;

  // Unpack the input item.
  logic [STORE_AW-1:0] in_index;
  logic [PIX_W-1:0]    in_pixel;
  logic [COORD_W-1:0]  in_sx, in_sy;

  always_comb begin
    in_index = in_tdata[STORE_AW-1:0];
    in_pixel = in_tdata[STORE_AW +: PIX_W];
    in_sx    = in_tdata[STORE_AW + PIX_W +: COORD_W];
    in_sy    = in_tdata[STORE_AW + PIX_W + COORD_W +: COORD_W];
    out_pop  = out_tvalid && out_tready;
  end

  bts_issue #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_issue (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser[0]),
    .in_index (in_index),
    .in_pixel (in_pixel),
    .in_sx    (in_sx),
    .in_sy    (in_sy),
    .out_pop  (out_pop),
    .mem_req  (mem_req),
    .tag      (tag),
    .weight   (weight)
  );

  bts_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  bts_accum #(
    .FRAC_BITS (FRAC_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag),
    .weight    (weight),
    .rd_data   (rd_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_color (out_tdata),
    .out_err   (out_tuser)
  );

endmodule

// ===== rtl/core/bts_checker.sv =====
module bts_sva_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [bts_pkg::IN_USER_W-1:0] in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bts_pkg::PIX_W-1:0]     out_tdata,
  input logic                          out_tuser
);
  import bts_pkg::*;

  // Samples accepted whose result has not been taken yet.
  logic [2:0] pending_r, pending_nxt;

  always_comb begin
    pending_nxt = pending_r
                + 3'((in_tvalid && in_tready) && (in_tuser[0] == CMD_SAMPLE))
                - 3'(out_tvalid && out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Out-of-range samples return zero color.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("range error with nonzero color");

  // Every result belongs to an earlier sample; writes produce none.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != '0)
    else $error("result without a pending sample");

endmodule

bind bilinear_texture_sampler_unit bts_sva_checker u_bts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/bts_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both stream channels, keeps its own copy of the
// pixel store and the image geometry, predicts the color of every sample and compares
// each returned item with the oldest prediction.
module bts_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // pixel_index, in_red, in_green, in_blue, in_alpha, sample_x, sample_y
  input  logic [bts_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [bts_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // out_red, out_green, out_blue, out_alpha
  input  logic [bts_pkg::PIX_W-1:0]      out_tdata,
  // range_error
  input  logic                           out_tuser,
  output int                             fail_count,
  output int                             pending
);
  import bts_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam int unsigned ONE  = 1 << FRAC;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       range_error;
  } texel_t;

  logic [PIX_W-1:0]      image_mem [0:STORE_DEPTH-1];
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  texel_t                texel_q [$];

  // A register value of zero acts as one, any value above the maximum acts as the maximum.
  function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] raw,
                                          input int unsigned lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // Bilinear blend of the four neighbors with exact fixed-point weights.
  function automatic texel_t bilerp_texel(input logic [COORD_W-1:0] sx,
                                          input logic [COORD_W-1:0] sy);
    int unsigned w, h, x0, y0, x1, y1, fx, fy, acc;
    int unsigned wt [NUM_TAPS];
    logic [PIX_W-1:0] px [NUM_TAPS];
    logic [PIX_W-1:0] rgba;
    texel_t t;
    w = eff_dim(width_reg, MAX_WIDTH_DEF);
    h = eff_dim(height_reg, MAX_HEIGHT_DEF);
    t = '0;
    // Beyond the last column or row: zero color with the error flag.
    if (sx > ((w - 1) << FRAC) || sy > ((h - 1) << FRAC)) begin
      t.range_error = 1'b1;
      return t;
    end
    x0 = sx >> FRAC;
    y0 = sy >> FRAC;
    fx = sx & (ONE - 1);
    fy = sy & (ONE - 1);
    // On the last column or row the far neighbor is the edge pixel itself.
    x1 = (x0 + 1 < w) ? x0 + 1 : x0;
    y1 = (y0 + 1 < h) ? y0 + 1 : y0;
    wt[0] = (ONE - fx) * (ONE - fy);
    wt[1] = fx * (ONE - fy);
    wt[2] = (ONE - fx) * fy;
    wt[3] = fx * fy;
    px[0] = image_mem[16'(y0 * w + x0)];
    px[1] = image_mem[16'(y0 * w + x1)];
    px[2] = image_mem[16'(y1 * w + x0)];
    px[3] = image_mem[16'(y1 * w + x1)];
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc = 0;
      for (int k = 0; k < NUM_TAPS; k++) begin
        acc += px[k][8*c +: 8] * wt[k];
      end
      rgba[8*c +: 8] = 8'(acc >> (2 * FRAC));
    end
    t.red   = rgba[7:0];
    t.green = rgba[15:8];
    t.blue  = rgba[23:16];
    t.alpha = rgba[31:24];
    return t;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // All observation happens on the rising edge, before the block updates its outputs.
  always @(posedge clk) begin
    texel_t want;
    if (!rst_n) begin
      width_reg  = 1;
      height_reg = 1;
      fail_count = 0;
      texel_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_IMAGE_WIDTH) width_reg = cfg_data;
        else if (cfg_idx == REG_IMAGE_HEIGHT) height_reg = cfg_data;
      end
      // A result can never belong to an item accepted on the same edge.
      if (out_tvalid && out_tready) begin
        if (texel_q.size() == 0) begin
          $error("result item arrived with no sample waiting for it");
          fail_count++;
        end else begin
          want = texel_q.pop_front();
          check_field("out_red", want.red, out_tdata[7:0]);
          check_field("out_green", want.green, out_tdata[15:8]);
          check_field("out_blue", want.blue, out_tdata[23:16]);
          check_field("out_alpha", want.alpha, out_tdata[31:24]);
          check_field("range_error", want.range_error, out_tuser);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == CMD_WRITE) begin
          image_mem[in_tdata[15:0]] = in_tdata[47:16];
        end else begin
          texel_q.push_back(bilerp_texel(in_tdata[63:48], in_tdata[79:64]));
        end
      end
    end
    pending = texel_q.size();
  end

endmodule

// ===== sim/bilinear_texture_sampler_unit_tb.sv =====
`timescale 1ns / 1ps

module bilinear_texture_sampler_unit_tb;
  import bts_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int NUM_PHASES   = 10;
  localparam int RANDOM_ITEMS = 120;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tuser;
  int                    fail_count;
  int                    pending;

  // Stimulus state: idling control, effective geometry and which store entries hold data.
  bit          calm    = 1'b0;
  int          gap_pct = 0;
  int unsigned img_w   = 1;
  int unsigned img_h   = 1;
  bit          written [0:STORE_DEPTH-1];
  int unsigned written_idx [$];
  int          cycles  = 0;
  int          stall_left = 0;
  int          run_left   = 0;

  always #2 clk = ~clk;

  bilinear_texture_sampler_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  bts_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side is always ready when calm; otherwise it alternates random stall bursts with runs of steady readiness.
  always @(negedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else begin
      if (stall_left == 0 && run_left == 0) begin
        if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 11);
        else run_left = $urandom_range(1, 40);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
        // A stall burst is always followed by some readiness.
        if (stall_left == 0) run_left = $urandom_range(1, 40);
      end else begin
        out_tready <= 1'b1;
        run_left--;
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(input logic [15:0] idx,
                                                     input logic [31:0] rgba,
                                                     input logic [15:0] sx,
                                                     input logic [15:0] sy);
    return {sy, sx, rgba, idx};
  endfunction

  // Entered and left at a falling edge; valid stays high between back-to-back items.
  task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] payload);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(1, 100) <= gap_pct) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= payload;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic put_pixel(input logic [15:0] idx, input logic [31:0] rgba);
    send_item(CMD_WRITE, pack_item(idx, rgba, 16'($urandom), 16'($urandom)));
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
  endtask

  task automatic sample_at(input logic [15:0] sx, input logic [15:0] sy);
    send_item(CMD_SAMPLE, pack_item(16'($urandom), $urandom, sx, sy));
  endtask

  // Writes random colors into a rectangle, cut off at the image border.
  task automatic fill_rect(input int unsigned x, input int unsigned y,
                           input int unsigned rw, input int unsigned rh);
    for (int unsigned yy = y; yy < y + rh && yy < img_h; yy++) begin
      for (int unsigned xx = x; xx < x + rw && xx < img_w; xx++) begin
        put_pixel(16'(yy * img_w + xx), $urandom);
      end
    end
  endtask

  // Only while idle: two register writes on consecutive cycles.
  task automatic set_geometry(input int unsigned raw_w, input int unsigned raw_h);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_IMAGE_WIDTH;
    cfg_data <= raw_w[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_idx  <= REG_IMAGE_HEIGHT;
    cfg_data <= raw_h[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we   <= 1'b0;
    img_w = (raw_w == 0) ? 1 : ((raw_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : raw_w);
    img_h = (raw_h == 0) ? 1 : ((raw_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : raw_h);
  endtask

  // Stop sending until every result is back, then let a write still in flight finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // An in-image coordinate whose four neighbors have all been written. The top-left
  // corner is always written in every phase, so it serves as the fallback.
  task automatic pick_inside(output logic [15:0] sx, output logic [15:0] sy);
    int unsigned idx, x0, y0, x1, y1, fx, fy, r;
    bit found;
    found = 1'b0;
    x0 = 0;
    y0 = 0;
    for (int t = 0; t < 40 && !found; t++) begin
      idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
      x0 = idx % img_w;
      y0 = idx / img_w;
      x1 = (x0 + 1 < img_w) ? x0 + 1 : x0;
      y1 = (y0 + 1 < img_h) ? y0 + 1 : y0;
      if (y0 < img_h && written[16'(y0 * img_w + x0)] && written[16'(y0 * img_w + x1)] &&
          written[16'(y1 * img_w + x0)] && written[16'(y1 * img_w + x1)]) begin
        found = 1'b1;
      end
    end
    if (!found) begin
      x0 = 0;
      y0 = 0;
    end
    r  = $urandom_range(0, 9);
    fx = (r < 3) ? 0 : ((r == 3) ? 255 : $urandom_range(0, 255));
    r  = $urandom_range(0, 9);
    fy = (r < 3) ? 0 : ((r == 3) ? 255 : $urandom_range(0, 255));
    // Exactly on the last column or row the fraction must be zero to stay inside.
    if (x0 == img_w - 1) fx = 0;
    if (y0 == img_h - 1) fy = 0;
    sx = 16'((x0 << 8) | fx);
    sy = 16'((y0 << 8) | fy);
  endtask

  // A coordinate beyond the image, often just one step past the edge.
  task automatic pick_outside(output logic [15:0] sx, output logic [15:0] sy);
    int unsigned lim_x, lim_y;
    lim_x = (img_w - 1) << 8;
    lim_y = (img_h - 1) << 8;
    sx = 16'($urandom);
    sy = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 0) sx = 16'(lim_x + 1);
      else sy = 16'(lim_y + 1);
    end else if (sx <= lim_x && sy <= lim_y) begin
      if ($urandom_range(0, 1) == 0) sx = 16'($urandom_range(lim_x + 1, 65535));
      else sy = 16'($urandom_range(lim_y + 1, 65535));
    end
  endtask

  initial begin
    int unsigned geo_w [NUM_PHASES];
    int unsigned geo_h [NUM_PHASES];
    int unsigned raw_w, raw_h, r;
    logic [15:0] sx, sy;

    geo_w = '{256, 3, 0, 300, 1, 256, 17, 2, 511, 0};
    geo_h = '{256, 5, 0, 2, 256, 1, 9, 2, 511, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset geometry is one pixel: the single pixel is its own neighbor on both axes.
    put_pixel(16'h0000, 32'hFFFF_FFFF);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'h0001, 16'h0000);
    sample_at(16'h0000, 16'h0100);
    settle();

    // A 2x2 image with extreme colors: corners, centers, edges and beyond the edges.
    set_geometry(2, 2);
    put_pixel(16'd0, 32'h0000_0000);
    put_pixel(16'd1, 32'hFFFF_FFFF);
    put_pixel(16'd2, 32'hFF00_FF00);
    put_pixel(16'd3, 32'h00FF_00FF);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'h0080, 16'h0080);
    sample_at(16'h00FF, 16'h00FF);
    sample_at(16'h0100, 16'h0100);
    sample_at(16'h0100, 16'h007F);
    sample_at(16'h0040, 16'h0100);
    sample_at(16'h0101, 16'h0000);
    sample_at(16'h0000, 16'h0101);
    sample_at(16'hFFFF, 16'hFFFF);
    put_pixel(16'hFFFF, $urandom);
    settle();

    // Random phases over several geometries; the last one runs without any idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      raw_w = geo_w[p];
      raw_h = geo_h[p];
      if (p == NUM_PHASES - 1) begin
        raw_w = $urandom_range(1, 24);
        raw_h = $urandom_range(1, 24);
        calm  = 1'b1;
      end
      gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
      set_geometry(raw_w, raw_h);

      fill_rect(0, 0, 3, 3);
      fill_rect((img_w > 3) ? img_w - 3 : 0, (img_h > 3) ? img_h - 3 : 0, 3, 3);
      repeat (2) begin
        fill_rect($urandom_range(0, img_w - 1), $urandom_range(0, img_h - 1),
                  $urandom_range(1, 5), $urandom_range(1, 5));
      end

      repeat (RANDOM_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          put_pixel(16'($urandom_range(0, img_h - 1) * img_w + $urandom_range(0, img_w - 1)),
                    $urandom);
        end else if (r < 20) begin
          put_pixel(16'($urandom), $urandom);
        end else if (r < 34) begin
          pick_outside(sx, sy);
          sample_at(sx, sy);
        end else begin
          pick_inside(sx, sy);
          sample_at(sx, sy);
        end
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bts_pkg.sv
rtl/core/bts_store.sv
rtl/core/bts_issue.sv
rtl/core/bts_accum.sv
rtl/core/bilinear_texture_sampler_unit.sv
rtl/core/bts_checker.sv
sim/bts_checker.sv
sim/bilinear_texture_sampler_unit_tb.sv
